>>> src/ptzcd_pkg.sv
package ptzcd_pkg;

    // Command kinds
    typedef enum logic [2:0] {
        KIND_PTZ     = 3'd0,
        KIND_FI      = 3'd1,
        KIND_PRESET  = 3'd2,
        KIND_CRUISE  = 3'd3,
        KIND_SCAN    = 3'd4,
        KIND_AUX     = 3'd5,
        KIND_UNKNOWN = 3'd6
    } kind_t;

    // Decode status codes
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_HEADER      = 4'd1,
        ST_VERSION     = 4'd2,
        ST_CHECKNIB    = 4'd3,
        ST_CHECKSUM    = 4'd4,
        ST_UNKNOWN     = 4'd5,
        ST_CONFLICT    = 4'd6,
        ST_PRESET0     = 4'd7,
        ST_UNSUPPORTED = 4'd8
    } status_t;

    // Frame and code constants
    localparam logic [7:0] HEADER_BYTE  = 8'hA5;
    localparam logic [7:0] PTZ_MASK     = 8'hC0;
    localparam logic [7:0] FI_MASK      = 8'hF0;
    localparam logic [7:0] FI_CODE      = 8'h40;
    localparam logic [7:0] PRESET_FIRST = 8'h81;
    localparam logic [7:0] PRESET_LAST  = 8'h83;
    localparam logic [7:0] CRUISE_FIRST = 8'h84;
    localparam logic [7:0] CRUISE_LAST  = 8'h88;
    localparam logic [7:0] SCAN_FIRST   = 8'h89;
    localparam logic [7:0] SCAN_LAST    = 8'h8A;
    localparam logic [7:0] AUX_FIRST    = 8'h8C;
    localparam logic [7:0] AUX_LAST     = 8'h8D;

    // Register map
    localparam logic REG_CHECKSUM_ENFORCE = 1'b0;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] code;
        status_t    pre_status;
        logic [7:0] sum_lo;
        logic [7:0] sum_hi;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [3:0] zoom_nib;
        logic [7:0] byte_8;
    } s1_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] code;
        status_t    status;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [3:0] zoom_nib;
    } s2_t;

endpackage

>>> src/ptzcd_frame_check.sv
module ptzcd_frame_check (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [7:0]       cmd_byte_1,
    input  logic [7:0]       cmd_byte_2,
    input  logic [7:0]       cmd_byte_3,
    input  logic [7:0]       cmd_byte_4,
    input  logic [7:0]       cmd_byte_5,
    input  logic [7:0]       cmd_byte_6,
    input  logic [7:0]       cmd_byte_7,
    input  logic [7:0]       cmd_byte_8,
    output ptzcd_pkg::s1_t   s1
);

    ptzcd_pkg::kind_t   kind;
    ptzcd_pkg::status_t pre_status;
    logic [3:0]         nib;
    logic               valid_reg;
    ptzcd_pkg::s1_t     data_reg;
    ptzcd_pkg::s1_t     data_next;

    // Sort by command code
    always_comb
    begin
        priority if ((cmd_byte_4 & ptzcd_pkg::PTZ_MASK) == 8'h00)
            kind = ptzcd_pkg::KIND_PTZ;
        else if ((cmd_byte_4 & ptzcd_pkg::FI_MASK) == ptzcd_pkg::FI_CODE)
            kind = ptzcd_pkg::KIND_FI;
        else if (cmd_byte_4 >= ptzcd_pkg::PRESET_FIRST && cmd_byte_4 <= ptzcd_pkg::PRESET_LAST)
            kind = ptzcd_pkg::KIND_PRESET;
        else if (cmd_byte_4 >= ptzcd_pkg::CRUISE_FIRST && cmd_byte_4 <= ptzcd_pkg::CRUISE_LAST)
            kind = ptzcd_pkg::KIND_CRUISE;
        else if (cmd_byte_4 >= ptzcd_pkg::SCAN_FIRST && cmd_byte_4 <= ptzcd_pkg::SCAN_LAST)
            kind = ptzcd_pkg::KIND_SCAN;
        else if (cmd_byte_4 >= ptzcd_pkg::AUX_FIRST && cmd_byte_4 <= ptzcd_pkg::AUX_LAST)
            kind = ptzcd_pkg::KIND_AUX;
        else
            kind = ptzcd_pkg::KIND_UNKNOWN;
    end

    // Kind support, header, version and check nibble
    assign nib = cmd_byte_1[7:4] + cmd_byte_1[3:0] + cmd_byte_2[7:4];

    always_comb
    begin
        priority if (kind == ptzcd_pkg::KIND_UNKNOWN)
            pre_status = ptzcd_pkg::ST_UNKNOWN;
        else if (kind == ptzcd_pkg::KIND_CRUISE || kind == ptzcd_pkg::KIND_SCAN
                 || kind == ptzcd_pkg::KIND_AUX)
            pre_status = ptzcd_pkg::ST_UNSUPPORTED;
        else if (cmd_byte_1 != ptzcd_pkg::HEADER_BYTE)
            pre_status = ptzcd_pkg::ST_HEADER;
        else if (cmd_byte_2[7:4] != 4'h0)
            pre_status = ptzcd_pkg::ST_VERSION;
        else if (cmd_byte_2[3:0] != nib)
            pre_status = ptzcd_pkg::ST_CHECKNIB;
        else
            pre_status = ptzcd_pkg::ST_OK;
    end

    always_comb
    begin
        data_next            = '0;
        data_next.kind       = kind;
        data_next.code       = cmd_byte_4;
        data_next.pre_status = pre_status;
        // Checksum split in two partial sums, finished next stage
        data_next.sum_lo     = cmd_byte_1 + cmd_byte_2 + cmd_byte_3 + cmd_byte_4;
        data_next.sum_hi     = cmd_byte_5 + cmd_byte_6 + cmd_byte_7;
        data_next.byte_5     = cmd_byte_5;
        data_next.byte_6     = cmd_byte_6;
        data_next.zoom_nib   = cmd_byte_7[7:4];
        data_next.byte_8     = cmd_byte_8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        s1       = data_reg;
        s1.valid = valid_reg;
    end

endmodule

>>> src/ptzcd_rule_check.sv
module ptzcd_rule_check (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             checksum_enforce,
    input  ptzcd_pkg::s1_t   s1,
    output ptzcd_pkg::s2_t   s2
);

    logic [7:0]         sum;
    logic               conflict;
    ptzcd_pkg::status_t status;
    logic               valid_reg;
    ptzcd_pkg::s2_t     data_reg;
    ptzcd_pkg::s2_t     data_next;

    assign sum = s1.sum_lo + s1.sum_hi;

    // Opposing direction bits
    always_comb
    begin
        if (s1.kind == ptzcd_pkg::KIND_PTZ)
            conflict = (s1.code[5:4] == 2'b11) || (s1.code[3:2] == 2'b11)
                       || (s1.code[1:0] == 2'b11);
        else
            conflict = (s1.code[3:2] == 2'b11) || (s1.code[1:0] == 2'b11);
    end

    // Final status, first failing check wins
    always_comb
    begin
        priority if (s1.pre_status != ptzcd_pkg::ST_OK)
            status = s1.pre_status;
        else if (checksum_enforce && s1.byte_8 != sum)
            status = ptzcd_pkg::ST_CHECKSUM;
        else if (s1.kind == ptzcd_pkg::KIND_PRESET)
            status = (s1.byte_6 == 8'h00) ? ptzcd_pkg::ST_PRESET0 : ptzcd_pkg::ST_OK;
        else if (conflict)
            status = ptzcd_pkg::ST_CONFLICT;
        else
            status = ptzcd_pkg::ST_OK;
    end

    always_comb
    begin
        data_next          = '0;
        data_next.kind     = s1.kind;
        data_next.code     = s1.code;
        data_next.status   = status;
        data_next.byte_5   = s1.byte_5;
        data_next.byte_6   = s1.byte_6;
        data_next.zoom_nib = s1.zoom_nib;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= s1.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        s2       = data_reg;
        s2.valid = valid_reg;
    end

endmodule

>>> src/ptzcd_field_out.sv
module ptzcd_field_out (
    input  logic             clk,
    input  logic             rst_n,
    input  ptzcd_pkg::s2_t   s2,
    output logic             done,
    output logic [3:0]       status,
    output logic [2:0]       command_kind,
    output logic [7:0]       command_code,
    output logic [5:0]       motion_bits,
    output logic [7:0]       first_speed,
    output logic [7:0]       second_speed,
    output logic [3:0]       zoom_speed,
    output logic [7:0]       preset_number
);

    logic       ok;
    logic       done_reg;
    logic [3:0] status_reg;
    logic [2:0] kind_reg;
    logic [7:0] code_reg;
    logic [5:0] motion_reg, motion_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [3:0] zoom_reg, zoom_next;
    logic [7:0] preset_reg, preset_next;

    assign ok = (s2.status == ptzcd_pkg::ST_OK);

    // Fields zeroed on error and for kinds that do not use them
    always_comb
    begin
        motion_next = 6'd0;
        first_next  = 8'd0;
        second_next = 8'd0;
        zoom_next   = 4'd0;
        preset_next = 8'd0;
        if (ok)
        begin
            unique case (s2.kind)
                ptzcd_pkg::KIND_PTZ:
                begin
                    motion_next = s2.code[5:0];
                    first_next  = s2.byte_5;
                    second_next = s2.byte_6;
                    zoom_next   = s2.zoom_nib;
                end
                ptzcd_pkg::KIND_FI:
                begin
                    motion_next = {2'b00, s2.code[3:0]};
                    first_next  = s2.byte_5;
                    second_next = s2.byte_6;
                end
                ptzcd_pkg::KIND_PRESET:
                begin
                    preset_next = s2.byte_6;
                end
                default:
                begin
                    motion_next = 6'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2.valid;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= s2.status;
        kind_reg   <= s2.kind;
        code_reg   <= s2.code;
        motion_reg <= motion_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        zoom_reg   <= zoom_next;
        preset_reg <= preset_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign command_kind  = kind_reg;
    assign command_code  = code_reg;
    assign motion_bits   = motion_reg;
    assign first_speed   = first_reg;
    assign second_speed  = second_reg;
    assign zoom_speed    = zoom_reg;
    assign preset_number = preset_reg;

endmodule

>>> src/ptz_control_command_decoder_top.sv
// PTZ control command decoder: one 8-byte request in, one decoded result out.
// Three register stages lie between an accepted request and its result on done:
// classify/frame checks, checksum/rule checks, output.
// Throughput: one request per cycle; busy is always low.
// Reset (rst_n, async active low) clears the stage valid bits and checksum_enforce.
// Results are strobed on done for one cycle and cannot be stalled by the receiver.
module ptz_control_command_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  cmd_byte_1,
    input  logic [7:0]  cmd_byte_2,
    input  logic [7:0]  cmd_byte_3,
    input  logic [7:0]  cmd_byte_4,
    input  logic [7:0]  cmd_byte_5,
    input  logic [7:0]  cmd_byte_6,
    input  logic [7:0]  cmd_byte_7,
    input  logic [7:0]  cmd_byte_8,
    // result channel
    output logic        done,
    output logic [3:0]  status,
    output logic [2:0]  command_kind,
    output logic [7:0]  command_code,
    output logic [5:0]  motion_bits,
    output logic [7:0]  first_speed,
    output logic [7:0]  second_speed,
    output logic [3:0]  zoom_speed,
    output logic [7:0]  preset_number,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ptzcd_pkg::s1_t s1;
    ptzcd_pkg::s2_t s2;
    logic           enforce_reg;
    logic           cfg_write;

    // Pipeline never stalls
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Configuration register
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enforce_reg <= 1'b0;
        else if (cfg_write && paddr[2] == ptzcd_pkg::REG_CHECKSUM_ENFORCE)
            enforce_reg <= pwdata[0];
    end

    assign prdata = (paddr[2] == ptzcd_pkg::REG_CHECKSUM_ENFORCE)
                    ? {31'd0, enforce_reg} : 32'd0;

    ptzcd_frame_check u_frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !busy),
        .cmd_byte_1 (cmd_byte_1),
        .cmd_byte_2 (cmd_byte_2),
        .cmd_byte_3 (cmd_byte_3),
        .cmd_byte_4 (cmd_byte_4),
        .cmd_byte_5 (cmd_byte_5),
        .cmd_byte_6 (cmd_byte_6),
        .cmd_byte_7 (cmd_byte_7),
        .cmd_byte_8 (cmd_byte_8),
        .s1         (s1)
    );

    ptzcd_rule_check u_rule_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .checksum_enforce (enforce_reg),
        .s1               (s1),
        .s2               (s2)
    );

    ptzcd_field_out u_field_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .s2            (s2),
        .done          (done),
        .status        (status),
        .command_kind  (command_kind),
        .command_code  (command_code),
        .motion_bits   (motion_bits),
        .first_speed   (first_speed),
        .second_speed  (second_speed),
        .zoom_speed    (zoom_speed),
        .preset_number (preset_number)
    );

endmodule
